// ===== rtl/gap_segment_derivative_filter_defines.svh =====
// Assertion macros shared by the gap-segment derivative filter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef GAP_SEGMENT_DERIVATIVE_FILTER_DEFINES_SVH
`define GAP_SEGMENT_DERIVATIVE_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define GSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gsd assertion failed");
`define GSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gsd assertion failed");
`else
`define GSD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GSD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/gsd_pkg.sv =====
// Package for the gap-segment derivative filter: types, register indexes, defaults.
// No dependencies; used by gsd_cell, gsd_scale and the top level.
package gsd_pkg;

  localparam int unsigned DefMaxSegment   = 15;
  localparam int unsigned DefMaxGap       = 8;
  localparam int unsigned DefMaxRow       = 4096;
  localparam int unsigned DefSampleBits   = 24;
  localparam int unsigned DefScaleFracBits = 16;

  localparam logic [3:0]  RstSegment = 4'd1;
  localparam logic [3:0]  RstGap     = 4'd1;
  localparam logic [1:0]  RstOrder   = 2'd1;
  localparam logic [31:0] RstScale   = 32'd65536;

  typedef enum logic [1:0] {
    REG_SEGMENT = 2'd0,
    REG_GAP     = 2'd1,
    REG_ORDER   = 2'd2,
    REG_SCALE   = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CELL_SMOOTH = 1'b0,
    CELL_DIFF   = 1'b1
  } cell_mode_e;

  // Flags that travel with each value along the chain.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } tok_t;

endpackage

// ===== rtl/gsd_cell.sv =====
// One cell of the filter chain: a moving-sum or a gap-difference stage with edge replication.
// Depends on gsd_pkg and the assertion macros in gap_segment_derivative_filter_defines.svh.
`include "gap_segment_derivative_filter_defines.svh"

module gsd_cell #(
  parameter int unsigned IN_W    = 24,
  parameter int unsigned OUT_W   = 28,
  parameter int unsigned MAX_DLY = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  gsd_pkg::cell_mode_e        mode_i,
  input  logic [$clog2(MAX_DLY+1)-1:0] dly_i,
  input  gsd_pkg::tok_t              in_tok_i,
  input  logic signed [IN_W-1:0]     in_val_i,
  output gsd_pkg::tok_t              out_tok_o,
  output logic signed [OUT_W-1:0]    out_val_o
);

  localparam int unsigned TAPS  = 2 * MAX_DLY + 1;
  localparam int unsigned TAP_W = $clog2(TAPS);
  localparam int unsigned DLY_W = $clog2(MAX_DLY + 1);
  localparam int unsigned PC_W  = $clog2(MAX_DLY + 2);

  logic signed [IN_W-1:0]  win_q [TAPS];
  logic signed [IN_W-1:0]  win_d [TAPS];
  logic signed [OUT_W-1:0] sum_q, sum_d;
  logic signed [OUT_W-1:0] val_q, val_d;
  logic [PC_W-1:0]         pc_q, pc_d;
  logic [DLY_W-1:0]        flush_q, flush_d;
  gsd_pkg::tok_t           tok_q, tok_d;

  logic                    push, first;
  logic signed [IN_W-1:0]  x, far;
  logic signed [OUT_W-1:0] xw, kw;
  logic [TAP_W-1:0]        tap;
  logic [PC_W-1:0]         dly_pc;

  always_comb begin
    push  = in_tok_i.vld || (flush_q != '0);
    // With no new value, the cell replays the newest one to replicate the right edge.
    x     = in_tok_i.vld ? in_val_i : win_q[0];
    first = in_tok_i.vld && in_tok_i.first;
    win_d[0] = x;
    for (int k = 1; k < TAPS; k++) begin
      win_d[k] = first ? x : win_q[k-1];
    end
    tap  = TAP_W'({dly_i, 1'b0});
    far  = win_d[tap];
    xw   = OUT_W'(x);
    kw   = $signed(OUT_W'({dly_i, 1'b1}));
    // The first value of a row fills the whole window, which replicates the left edge.
    sum_d = first ? OUT_W'(xw * kw) : OUT_W'(sum_q + xw - OUT_W'(win_q[tap]));
    val_d = (mode_i == gsd_pkg::CELL_SMOOTH) ? sum_d : OUT_W'(OUT_W'(win_d[0]) - OUT_W'(far));

    dly_pc = PC_W'(dly_i) + PC_W'(1);
    pc_d   = pc_q;
    if (first) begin
      pc_d = PC_W'(1);
    end else if (push && (pc_q != dly_pc)) begin
      pc_d = pc_q + PC_W'(1);
    end

    flush_d = flush_q;
    if (in_tok_i.vld && in_tok_i.last) begin
      flush_d = dly_i;
    end else if (!in_tok_i.vld && (flush_q != '0)) begin
      flush_d = flush_q - DLY_W'(1);
    end

    tok_d.vld   = push && (pc_d == dly_pc);
    tok_d.first = tok_d.vld && (first || (pc_q == PC_W'(dly_i)));
    tok_d.last  = (in_tok_i.vld && in_tok_i.last && (dly_i == '0)) ||
                  (!in_tok_i.vld && (flush_q == DLY_W'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      flush_q <= '0;
      tok_q   <= '0;
    end else if (en_i) begin
      pc_q    <= pc_d;
      flush_q <= flush_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && push) begin
      win_q <= win_d;
      sum_q <= sum_d;
      val_q <= val_d;
    end
  end

  assign out_tok_o = tok_q;
  assign out_val_o = val_q;

  `GSD_ASSERT_IMP(a_last_is_valid, clk_i, rst_ni, tok_q.last, tok_q.vld)
  `GSD_ASSERT_IMP(a_no_input_in_flush, clk_i, rst_ni, flush_q != '0, !in_tok_i.vld)
  `GSD_ASSERT_NXT(a_first_has_lag, clk_i, rst_ni,
                  en_i && first && (dly_i != '0), !tok_q.vld)

endmodule

// ===== rtl/gsd_scale.sv =====
// Output scaling: product of the difference and the Q-format factor, rounded and saturated.
// Depends on gsd_pkg; three registered stages, the last one drives the output stream.
module gsd_scale #(
  parameter int unsigned DW   = 34,
  parameter int unsigned FRAC = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  gsd_pkg::tok_t        in_tok_i,
  input  logic signed [DW-1:0] d_i,
  input  logic [31:0]          scale_i,
  output gsd_pkg::tok_t        out_tok_o,
  output logic [31:0]          out_val_o
);

  localparam int unsigned MD_W = (DW > 32) ? DW : 33;
  localparam int unsigned HW   = MD_W - 32;
  localparam int unsigned AW   = HW + 32;
  localparam int unsigned QW   = HW + 65;
  localparam logic [64:0] Round = 65'(1) << (FRAC - 1);

  gsd_pkg::tok_t      tok_a_q, tok_b_q, tok_c_q;
  logic               neg_a_q, neg_b_q;
  logic [MD_W-1:0]    md_a_q, md_a_d;
  logic [31:0]        ms_a_q, ms_a_d;
  logic [AW-1:0]      a_b_q, a_b_d;
  logic [64:0]        b_b_q, b_b_d;
  logic [31:0]        res_q, res_d;

  logic signed [MD_W:0] dx, mag;
  logic signed [32:0]   sx, smag;
  logic [QW-1:0]        q, lim;

  always_comb begin
    dx     = (MD_W+1)'(d_i);
    mag    = dx[MD_W] ? -dx : dx;
    md_a_d = mag[MD_W-1:0];
    sx     = $signed({scale_i[31], scale_i});
    smag   = sx[32] ? -sx : sx;
    ms_a_d = smag[31:0];

    a_b_d = AW'(AW'(md_a_q[MD_W-1:32]) * AW'(ms_a_q));
    b_b_d = 65'(65'(md_a_q[31:0]) * 65'(ms_a_q)) + Round;

    q   = (QW'(a_b_q) << (32 - FRAC)) + QW'(b_b_q >> FRAC);
    lim = neg_b_q ? QW'(33'h080000000) : QW'(32'h7FFFFFFF);
    if ((a_b_q > AW'(32'h7FFFFFFF)) || (q > lim)) begin
      q = lim;
    end
    res_d = neg_b_q ? (32'd0 - q[31:0]) : q[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_a_q <= '0;
      tok_b_q <= '0;
      tok_c_q <= '0;
    end else if (en_i) begin
      tok_a_q <= in_tok_i;
      tok_b_q <= tok_a_q;
      tok_c_q <= tok_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q <= d_i[DW-1] ^ scale_i[31];
      md_a_q  <= md_a_d;
      ms_a_q  <= ms_a_d;
      neg_b_q <= neg_a_q;
      a_b_q   <= a_b_d;
      b_b_q   <= b_b_d;
      res_q   <= res_d;
    end
  end

  assign out_tok_o = tok_c_q;
  assign out_val_o = res_q;

endmodule

// ===== rtl/gap_segment_derivative_filter.sv =====
// Gap-segment derivative filter. A row of signed samples enters on the input stream, one request
// per cycle while the output is not stalled, the final sample marked by tlast (or forced at
// position MAX_ROW-1). Four chained cells smooth, difference, smooth and difference again (the
// last two only for second order), each replicating the row's edge values; a three-stage scaler
// applies output_scale. Result j leaves once sample j+L is in, L = order*(segment/2 + gap); it
// passes through the registers of the active cells and then the three scaler stages. A
// result waiting on the output stalls the whole chain and the input. After the row end the
// input is held off while the cells flush the remaining L+1 results; the next row's first
// sample is taken once the row's final result has been delivered. Registers are latched at a
// row start.
module gap_segment_derivative_filter #(
  parameter int unsigned MAX_SEGMENT     = gsd_pkg::DefMaxSegment,
  parameter int unsigned MAX_GAP         = gsd_pkg::DefMaxGap,
  parameter int unsigned MAX_ROW         = gsd_pkg::DefMaxRow,
  parameter int unsigned SAMPLE_BITS     = gsd_pkg::DefSampleBits,
  parameter int unsigned SCALE_FRAC_BITS = gsd_pkg::DefScaleFracBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // derivative
  output logic [31:0] m_axis_tdata,
  output logic m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned MAX_HALF = MAX_SEGMENT / 2;
  localparam int unsigned MAX_DLY  = (MAX_HALF > MAX_GAP) ? MAX_HALF : MAX_GAP;
  localparam int unsigned DLY_W    = $clog2(MAX_DLY + 1);
  localparam int unsigned GS       = $clog2(MAX_SEGMENT + 1);
  localparam int unsigned POS_W    = $clog2(MAX_ROW);
  localparam int unsigned W1       = SAMPLE_BITS + GS;
  localparam int unsigned W2       = W1 + 1;
  localparam int unsigned W3       = W2 + GS;
  localparam int unsigned W4       = W3 + 1;

  logic [3:0]  seg_q, gap_q;
  logic [1:0]  ord_q;
  logic [31:0] scale_q;
  logic        wr_en;

  logic [DLY_W-1:0] half_q, half_d, gapd_q, gapd_d;
  logic [DLY_W-1:0] half_use, gapd_use;
  logic             ord2_q;
  logic [31:0]      act_scale_q;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             busy_q, busy_d;
  logic             en, acc, row_last, row_idle;

  gsd_pkg::tok_t           tok0, tok1, tok2, tok3, tok4, tok2_in, tail_tok, out_tok;
  logic signed [W1-1:0]    val1;
  logic signed [W2-1:0]    val2;
  logic signed [W3-1:0]    val3;
  logic signed [W4-1:0]    val4, tail_val;

  // Configuration port.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= gsd_pkg::RstSegment;
      gap_q   <= gsd_pkg::RstGap;
      ord_q   <= gsd_pkg::RstOrder;
      scale_q <= gsd_pkg::RstScale;
    end else if (wr_en) begin
      unique case (gsd_pkg::reg_idx_e'(paddr[3:2]))
        gsd_pkg::REG_SEGMENT: seg_q   <= pwdata[3:0];
        gsd_pkg::REG_GAP:     gap_q   <= pwdata[3:0];
        gsd_pkg::REG_ORDER:   ord_q   <= pwdata[1:0];
        gsd_pkg::REG_SCALE:   scale_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (gsd_pkg::reg_idx_e'(paddr[3:2]))
      gsd_pkg::REG_SEGMENT: prdata = {28'd0, seg_q};
      gsd_pkg::REG_GAP:     prdata = {28'd0, gap_q};
      gsd_pkg::REG_ORDER:   prdata = {30'd0, ord_q};
      gsd_pkg::REG_SCALE:   prdata = scale_q;
      default:              prdata = '0;
    endcase
  end

  // Effective settings: even segments drop to the odd value below (zero gives one), ranges clamp.
  always_comb begin
    int s;
    int g;
    s = int'(seg_q);
    if (s > int'(MAX_SEGMENT)) s = int'(MAX_SEGMENT);
    if ((s & 1) == 0) s = (s == 0) ? 1 : s - 1;
    g = int'(gap_q);
    if (g < 1) g = 1;
    if (g > int'(MAX_GAP)) g = int'(MAX_GAP);
    half_d = DLY_W'(s >> 1);
    gapd_d = DLY_W'(g);
  end

  // Stream control.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !busy_q;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign row_last      = s_axis_tlast || (pos_q == POS_W'(MAX_ROW - 1));
  assign row_idle      = !busy_q && (pos_q == '0);

  // The first sample of a row already sees the current register values.
  assign half_use = row_idle ? half_d : half_q;
  assign gapd_use = row_idle ? gapd_d : gapd_q;

  always_comb begin
    pos_d  = pos_q;
    busy_d = busy_q;
    if (acc) begin
      pos_d  = row_last ? '0 : pos_q + POS_W'(1);
      busy_d = row_last;
    end
    if (m_axis_tvalid && m_axis_tready && m_axis_tlast) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      busy_q      <= 1'b0;
      half_q      <= '0;
      gapd_q      <= DLY_W'(1);
      ord2_q      <= 1'b0;
      act_scale_q <= gsd_pkg::RstScale;
    end else begin
      pos_q  <= pos_d;
      busy_q <= busy_d;
      // Between rows the settings follow the registers; inside a row they hold.
      if (row_idle) begin
        half_q      <= half_d;
        gapd_q      <= gapd_d;
        ord2_q      <= (ord_q >= 2'd2);
        act_scale_q <= scale_q;
      end
    end
  end

  assign tok0.vld   = acc;
  assign tok0.first = (pos_q == '0);
  assign tok0.last  = row_last;

  gsd_cell #(.IN_W(SAMPLE_BITS), .OUT_W(W1), .MAX_DLY(MAX_DLY)) u_smooth1 (
    .clk_i, .rst_ni, .en_i(en), .mode_i(gsd_pkg::CELL_SMOOTH), .dly_i(half_use),
    .in_tok_i(tok0), .in_val_i($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .out_tok_o(tok1), .out_val_o(val1)
  );

  gsd_cell #(.IN_W(W1), .OUT_W(W2), .MAX_DLY(MAX_DLY)) u_diff1 (
    .clk_i, .rst_ni, .en_i(en), .mode_i(gsd_pkg::CELL_DIFF), .dly_i(gapd_use),
    .in_tok_i(tok1), .in_val_i(val1), .out_tok_o(tok2), .out_val_o(val2)
  );

  // The second pair only sees data for second-order rows.
  always_comb begin
    tok2_in     = tok2;
    tok2_in.vld = tok2.vld && ord2_q;
  end

  gsd_cell #(.IN_W(W2), .OUT_W(W3), .MAX_DLY(MAX_DLY)) u_smooth2 (
    .clk_i, .rst_ni, .en_i(en), .mode_i(gsd_pkg::CELL_SMOOTH), .dly_i(half_use),
    .in_tok_i(tok2_in), .in_val_i(val2), .out_tok_o(tok3), .out_val_o(val3)
  );

  gsd_cell #(.IN_W(W3), .OUT_W(W4), .MAX_DLY(MAX_DLY)) u_diff2 (
    .clk_i, .rst_ni, .en_i(en), .mode_i(gsd_pkg::CELL_DIFF), .dly_i(gapd_use),
    .in_tok_i(tok3), .in_val_i(val3), .out_tok_o(tok4), .out_val_o(val4)
  );

  always_comb begin
    if (ord2_q) begin
      tail_tok = tok4;
      tail_val = val4;
    end else begin
      tail_tok = tok2;
      tail_val = W4'(val2);
    end
  end

  gsd_scale #(.DW(W4), .FRAC(SCALE_FRAC_BITS)) u_scale (
    .clk_i, .rst_ni, .en_i(en), .in_tok_i(tail_tok), .d_i(tail_val),
    .scale_i(act_scale_q), .out_tok_o(out_tok), .out_val_o(m_axis_tdata)
  );

  assign m_axis_tvalid = out_tok.vld;
  assign m_axis_tlast  = out_tok.last;

endmodule

// ===== tb/gap_segment_derivative_filter_test.sv =====
// Self-checking testbench for the gap-segment derivative filter.
// It drives sample rows over the input stream and programs registers over APB.
// A built-in row model predicts every derivative. Needs gsd_pkg and the top level RTL.
`timescale 1ns / 100ps

module gap_segment_derivative_filter_test;

  localparam int RowMax    = 4096;
  localparam int FracBits  = 16;
  localparam int CycleLimit = 600000;

  typedef struct {
    logic [23:0] sample;
    logic        last;
  } sample_req_t;

  typedef struct {
    logic [31:0] deriv;
    logic        last;
  } deriv_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gap_segment_derivative_filter DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sample_req_t sample_q[$];
  deriv_t      deriv_q[$];
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          errors = 0;
  int          cycles = 0;
  logic        taken = 1'b0;

  // Register copies, and the values latched at the start of a row.
  logic [3:0]  reg_seg = gsd_pkg::RstSegment;
  logic [3:0]  reg_gap = gsd_pkg::RstGap;
  logic [1:0]  reg_order = gsd_pkg::RstOrder;
  logic [31:0] reg_scale = gsd_pkg::RstScale;
  longint      row_half, row_gap, row_order, row_lag, row_scale;
  longint      row_buf[RowMax];
  int          row_pos = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("gap_segment_derivative_filter_test NOT OK");
      $finish;
    end
  end

  function automatic longint clip(longint i, longint n);
    if (i < 0) return 0;
    if (i >= n) return n - 1;
    return i;
  endfunction

  function automatic longint smooth_a(longint j, longint n);
    longint acc = 0;
    for (longint k = -row_half; k <= row_half; k++) acc += row_buf[clip(j + k, n)];
    return acc;
  endfunction

  function automatic longint diff_a(longint j, longint n);
    return smooth_a(clip(j + row_gap, n), n) - smooth_a(clip(j - row_gap, n), n);
  endfunction

  function automatic longint smooth_b(longint j, longint n);
    longint acc = 0;
    for (longint k = -row_half; k <= row_half; k++) acc += diff_a(clip(j + k, n), n);
    return acc;
  endfunction

  function automatic logic [31:0] scaled(longint d);
    logic neg;
    logic [63:0] md, ms, a, b, q, lim;
    neg = d < 0;
    md = neg ? -d : d;
    if (row_scale < 0) begin
      neg = !neg;
      ms = -row_scale;
    end else begin
      ms = row_scale;
    end
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    a = (md >> 32) * ms;
    b = (md & 64'hFFFF_FFFF) * ms + (64'd1 << (FracBits - 1));
    if (a > 64'h7FFF_FFFF) begin
      q = lim;
    end else begin
      q = (a << (32 - FracBits)) + (b >> FracBits);
      if (q > lim) q = lim;
    end
    if (neg) q = -q;
    return q[31:0];
  endfunction

  function automatic logic [31:0] deriv_at(longint j, longint n);
    longint d;
    if (row_order == 2) d = smooth_b(clip(j + row_gap, n), n) - smooth_b(clip(j - row_gap, n), n);
    else d = diff_a(j, n);
    return scaled(d);
  endfunction

  task automatic predict_sample(logic [23:0] raw, logic mark);
    longint s, n, first;
    deriv_t r;
    if (row_pos == 0) begin
      s = (reg_seg > 15) ? 15 : reg_seg;
      if (s[0] == 1'b0) s = (s == 0) ? 1 : s - 1;
      row_half = s / 2;
      row_gap = (reg_gap < 1) ? 1 : ((reg_gap > 8) ? 8 : reg_gap);
      row_order = (reg_order >= 2) ? 2 : 1;
      row_lag = row_order * (row_half + row_gap);
      row_scale = longint'($signed(reg_scale));
    end
    row_buf[row_pos] = longint'($signed(raw));
    n = row_pos + 1;
    if (mark || n >= RowMax) begin
      first = (row_pos - row_lag < 0) ? 0 : row_pos - row_lag;
      for (longint j = first; j <= row_pos; j++) begin
        r.deriv = deriv_at(j, n);
        r.last = (j == row_pos);
        deriv_q.push_back(r);
      end
      row_pos = 0;
    end else begin
      if (row_pos >= row_lag) begin
        r.deriv = deriv_at(row_pos - row_lag, n);
        r.last = 1'b0;
        deriv_q.push_back(r);
      end
      row_pos = row_pos + 1;
    end
  endtask

  // Input driver: a request stays on the bus until it is taken.
  always @(negedge clk_i) begin
    sample_req_t it;
    if (rst_ni) begin
      if (!s_axis_tvalid || taken) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          it = sample_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= it.sample;
          s_axis_tlast <= it.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    deriv_t e;
    taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_sample(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (deriv_q.size() == 0) begin
          $error("unexpected result derivative=%h last_out=%b", m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          e = deriv_q.pop_front();
          if (m_axis_tdata !== e.deriv) begin
            $error("derivative expected %h actual %h", e.deriv, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last_out expected %b actual %b", e.last, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  task automatic reg_write(gsd_pkg::reg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      gsd_pkg::REG_SEGMENT: reg_seg = v[3:0];
      gsd_pkg::REG_GAP:     reg_gap = v[3:0];
      gsd_pkg::REG_ORDER:   reg_order = v[1:0];
      gsd_pkg::REG_SCALE:   reg_scale = v;
      default: ;
    endcase
  endtask

  task automatic push_sample(logic [23:0] s, logic l);
    sample_req_t it;
    it.sample = s;
    it.last = l;
    sample_q.push_back(it);
  endtask

  task automatic random_rows(int count);
    int len;
    logic [23:0] s;
    for (int r = 0; r < count; r++) begin
      len = ($urandom_range(9) == 0) ? int'($urandom_range(1, 4)) : int'($urandom_range(5, 24));
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(7))
          0: s = 24'h7FFFFF;
          1: s = 24'h800000;
          2: s = 24'($urandom_range(255));
          default: s = 24'($urandom);
        endcase
        push_sample(s, i == len - 1);
      end
    end
  endtask

  task automatic drain(int settle);
    while (sample_q.size() > 0 || s_axis_tvalid || deriv_q.size() > 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [3:0] seg, logic [3:0] gap, logic [1:0] ord, logic [31:0] sc);
    reg_write(gsd_pkg::REG_SEGMENT, {28'd0, seg});
    reg_write(gsd_pkg::REG_GAP, {28'd0, gap});
    reg_write(gsd_pkg::REG_ORDER, {30'd0, ord});
    reg_write(gsd_pkg::REG_SCALE, sc);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows at reset settings: single-sample row, extremes, short rows.
    push_sample(24'h123456, 1'b1);
    for (int i = 0; i < 4; i++) push_sample(24'h7FFFFF, i == 3);
    for (int i = 0; i < 4; i++) push_sample(24'h800000, i == 3);
    push_sample(24'h800000, 1'b0);
    push_sample(24'h7FFFFF, 1'b0);
    push_sample(24'h000000, 1'b1);
    for (int i = 0; i < 8; i++) push_sample(i[0] ? 24'hFFFFFF : 24'h000001, i == 7);
    drain(40);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      case (ph)
        0: set_regs(4'd15, 4'd8, 2'd2, 32'h7FFFFFFF);
        1: set_regs(4'd0, 4'd0, 2'd0, 32'h80000000);
        2: set_regs(4'd14, 4'd9, 2'd3, 32'd0);
        3: set_regs(4'd1, 4'd1, 2'd1, 32'd65536);
        4: set_regs(4'd15, 4'd15, 2'd2, $urandom);
        5: set_regs(4'd3, 4'd8, 2'd1, 32'hFFFF0000);
        default: set_regs(4'($urandom), 4'($urandom), 2'($urandom), $urandom);
      endcase
      random_rows(2);
      drain(40);
    end

    drain(60);
    if (errors == 0) begin
      $display("gap_segment_derivative_filter_test OK");
    end else begin
      $display("gap_segment_derivative_filter_test NOT OK");
    end
    $finish;
  end

endmodule
